// ===== rtl/des_pkg.sv =====
// Shared types, codes and helpers for the double exponential smoother.
`default_nettype none

package des_pkg;

  // Field and register widths
  localparam int unsigned DataW = 32;
  localparam int unsigned GainW = 17;
  localparam int unsigned FuncW = 2;

  // Gain of exactly 1.0 in Q1.16
  localparam logic [GainW-1:0] GAIN_ONE = 17'd65536;

  // Configuration reset values
  localparam logic [GainW-1:0] LEVEL_GAIN_RST = 17'd9830;
  localparam logic [GainW-1:0] TREND_GAIN_RST = 17'd19661;

  // Configuration register indexes
  localparam logic REG_LEVEL_GAIN = 1'b0;
  localparam logic REG_TREND_GAIN = 1'b1;

  // Function codes of an input transaction
  localparam logic [FuncW-1:0] FUNC_NEW    = 2'd0;
  localparam logic [FuncW-1:0] FUNC_REPEAT = 2'd1;
  localparam logic [FuncW-1:0] FUNC_SET    = 2'd2;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL1,
    S_ADD1,
    S_DIFF2,
    S_MUL2,
    S_ADD2
  } state_t;

  // Limit a gain to 1.0
  function automatic logic [GainW-1:0] clamp_gain(input logic [GainW-1:0] g);
    clamp_gain = (g > GAIN_ONE) ? GAIN_ONE : g;
  endfunction

  // Saturate a 37-bit signed sum to the signed 32-bit range
  function automatic logic signed [DataW-1:0] sat32(input logic signed [36:0] v);
    logic all_same;
    all_same = (v[36:31] == 6'b000000) || (v[36:31] == 6'b111111);
    if (all_same) begin
      sat32 = v[31:0];
    end else if (v[36]) begin
      sat32 = {1'b1, {(DataW-1){1'b0}}};
    end else begin
      sat32 = {1'b0, {(DataW-1){1'b1}}};
    end
  endfunction

endpackage

`default_nettype wire

// ===== rtl/double_exponential_smoother_top.sv =====
// Holt double exponential smoother: one shared multiplier under a small sequencer.
`default_nettype none

// A new-sample or repeat transaction occupies the block from the accepting edge
// until it can accept again; its steps come from the single 34x18 multiplier,
// used once for the level update and once for the trend update, each followed by
// an add-and-saturate step and separated by a difference step. The result is held
// in an output register, so a new input is taken while a result still waits; the
// final step only stalls when that register is still full. A set-level
// transaction leaves the block idle and gives no result; an unused function code
// is taken and dropped. Gains above 1.0 act as 1.0. Configuration writes are
// taken at any time but are meant for idle periods.
module double_exponential_smoother_top (
  input  wire                               clk,
  input  wire                               rst,
  // Input channel
  input  wire                               sample_valid,
  output logic                              sample_stall,
  input  wire  [des_pkg::FuncW-1:0]         func,
  input  wire  signed [des_pkg::DataW-1:0]  sample,
  // Result channel
  output logic                              result_valid,
  input  wire                               result_stall,
  output logic signed [des_pkg::DataW-1:0]  smoothed,
  output logic signed [des_pkg::DataW-1:0]  trend,
  // Configuration port
  input  wire                               write_enable,
  input  wire                               reg_index,
  input  wire  [des_pkg::GainW-1:0]         write_data
);

  import des_pkg::*;

  state_t state, state_next;

  // Architectural state
  logic signed [DataW-1:0] level;
  logic signed [DataW-1:0] slope;
  logic signed [DataW-1:0] held;
  logic [GainW-1:0]        level_gain;
  logic [GainW-1:0]        trend_gain;

  // Working registers
  logic signed [32:0]      pred;
  logic signed [33:0]      diff;
  logic signed [51:0]      prod;
  logic signed [DataW-1:0] new_level;

  // Control
  logic in_accept;
  logic out_accept;
  logic finish;

  // Datapath nets
  logic signed [DataW-1:0] sel_sample;
  logic signed [32:0]      pred_in;
  logic signed [33:0]      diff_in;
  logic [GainW-1:0]        mul_gain;
  logic signed [51:0]      mul_out;
  logic signed [36:0]      sum_level;
  logic signed [36:0]      sum_trend;
  logic signed [33:0]      diff_trend;

  assign in_accept  = sample_valid && !sample_stall;
  assign out_accept = result_valid && !result_stall;

  // Next state and handshake outputs
  always_comb begin
    state_next   = state;
    sample_stall = 1'b1;
    finish       = 1'b0;
    case (state)
      S_IDLE: begin
        sample_stall = 1'b0;
        if (sample_valid && (func == FUNC_NEW || func == FUNC_REPEAT)) begin
          state_next = S_MUL1;
        end
      end
      S_MUL1:  state_next = S_ADD1;
      S_ADD1:  state_next = S_DIFF2;
      S_DIFF2: state_next = S_MUL2;
      S_MUL2:  state_next = S_ADD2;
      S_ADD2: begin
        if (!result_valid || !result_stall) begin
          finish     = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Prediction and level error at the accepting edge
  assign sel_sample = (func == FUNC_NEW) ? sample : held;
  assign pred_in    = {level[31], level} + {slope[31], slope};
  assign diff_in    = {{2{sel_sample[31]}}, sel_sample} - {pred_in[32], pred_in};

  // Shared multiplier: level gain first, trend gain second
  assign mul_gain = (state == S_MUL1) ? clamp_gain(level_gain) : clamp_gain(trend_gain);
  assign mul_out  = diff * $signed({1'b0, mul_gain});

  // Scaled products floor toward minus infinity through the arithmetic shift
  assign sum_level  = {{4{pred[32]}}, pred} + {prod[51], prod[51:16]};
  assign sum_trend  = {{5{slope[31]}}, slope} + {prod[51], prod[51:16]};
  assign diff_trend = {{2{new_level[31]}}, new_level} - {{2{level[31]}}, level}
                      - {{2{slope[31]}}, slope};

  // Working registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        pred <= pred_in;
        diff <= diff_in;
      end
      S_MUL1:  prod <= mul_out;
      S_ADD1:  new_level <= sat32(sum_level);
      S_DIFF2: diff <= diff_trend;
      S_MUL2:  prod <= mul_out;
      default: ;
    endcase
  end

  // Level, trend, held sample and gains
  always_ff @(posedge clk) begin
    if (rst) begin
      level      <= '0;
      slope      <= '0;
      held       <= '0;
      level_gain <= LEVEL_GAIN_RST;
      trend_gain <= TREND_GAIN_RST;
    end else begin
      if (write_enable) begin
        if (reg_index == REG_LEVEL_GAIN) begin
          level_gain <= write_data;
        end else begin
          trend_gain <= write_data;
        end
      end
      if (in_accept && func == FUNC_NEW) begin
        held <= sample;
      end
      if (in_accept && func == FUNC_SET) begin
        level <= sample;
      end
      if (finish) begin
        level <= new_level;
        slope <= sat32(sum_trend);
      end
    end
  end

  // Output register: load on finish, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (finish) begin
      result_valid <= 1'b1;
    end else if (out_accept) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      smoothed <= new_level;
      trend    <= sat32(sum_trend);
    end
  end

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// Self-checking testbench for the double exponential smoother top level.
`timescale 1ns / 100ps

module tb_top;
  import des_pkg::*;

  localparam logic [FuncW-1:0] FUNC_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 20;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int RANDOM_PHASES = 10;
  localparam int ITEMS_PER_PHASE = 105;

  typedef struct {
    logic [FuncW-1:0]         func;
    logic signed [DataW-1:0]  value;
    bit                       drain;
  } smoother_item_t;

  typedef struct {
    logic signed [DataW-1:0] smoothed;
    logic signed [DataW-1:0] trend;
  } smoother_out_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     sample_valid = 1'b0;
  logic                     sample_stall;
  logic [FuncW-1:0]         func = '0;
  logic signed [DataW-1:0]  sample = '0;
  logic                     result_valid;
  logic                     result_stall = 1'b0;
  logic signed [DataW-1:0]  smoothed;
  logic signed [DataW-1:0]  trend;
  logic                     write_enable = 1'b0;
  logic                     reg_index = 1'b0;
  logic [GainW-1:0]         write_data = '0;

  smoother_item_t  pending_items[$];
  smoother_out_t   expected_out[$];
  int              errors = 0;
  int              idle_cycles = 0;

  // Smoother state as the testbench sees it
  logic signed [DataW-1:0]  mdl_level = '0;
  logic signed [DataW-1:0]  mdl_slope = '0;
  logic signed [DataW-1:0]  mdl_held = '0;
  logic [GainW-1:0]         mdl_alpha = LEVEL_GAIN_RST;
  logic [GainW-1:0]         mdl_beta = TREND_GAIN_RST;

  // Ramp used to build smooth random sample streams
  logic signed [DataW-1:0]  ramp_base = '0;
  logic signed [DataW-1:0]  ramp_step = 32'sd65536;

  int send_gap = 0;
  int send_calm = 0;
  int recv_gap = 0;
  int recv_calm = 0;

  double_exponential_smoother_top u_top (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .func         (func),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .smoothed     (smoothed),
    .trend        (trend),
    .write_enable (write_enable),
    .reg_index    (reg_index),
    .write_data   (write_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Clip a wide value to the signed 32-bit range
  function automatic logic signed [DataW-1:0] clip_s32(input longint v);
    if (v > 64'sd2147483647) begin
      clip_s32 = 32'sh7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      clip_s32 = 32'sh8000_0000;
    end else begin
      clip_s32 = v[31:0];
    end
  endfunction

  // Advance the smoother state by one transaction; return 1 when it gives a result
  function automatic bit holt_step(input logic [FuncW-1:0] f,
                                   input logic signed [DataW-1:0] s,
                                   output logic signed [DataW-1:0] lvl_out,
                                   output logic signed [DataW-1:0] tr_out);
    longint a, b, pred, new_lvl, new_tr;
    lvl_out = '0;
    tr_out = '0;
    if (f == FUNC_SET) begin
      mdl_level = s;
      return 1'b0;
    end
    if (f != FUNC_NEW && f != FUNC_REPEAT) begin
      return 1'b0;
    end
    if (f == FUNC_NEW) begin
      mdl_held = s;
    end
    a = (mdl_alpha > 17'd65536) ? 64'sd65536 : longint'(mdl_alpha);
    b = (mdl_beta > 17'd65536) ? 64'sd65536 : longint'(mdl_beta);
    pred = longint'(mdl_level) + longint'(mdl_slope);
    new_lvl = longint'(clip_s32(pred + ((a * (longint'(mdl_held) - pred)) >>> 16)));
    new_tr = longint'(mdl_slope)
             + ((b * ((new_lvl - longint'(mdl_level)) - longint'(mdl_slope))) >>> 16);
    mdl_level = new_lvl[31:0];
    mdl_slope = clip_s32(new_tr);
    lvl_out = mdl_level;
    tr_out = mdl_slope;
    return 1'b1;
  endfunction

  // Draw an idle count, with occasional stretches of back-to-back traffic
  function automatic int draw_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 12);
  endfunction

  // Pick a sample: mostly a noisy ramp, sometimes extremes or raw noise
  function automatic logic signed [DataW-1:0] pick_sample();
    int unsigned sel;
    int noise;
    sel = $urandom_range(0, 99);
    noise = int'($urandom_range(0, 262143)) - 131072;
    if (sel < 12) begin
      pick_sample = $urandom;
    end else if (sel < 15) begin
      pick_sample = 32'sh7FFF_FFFF;
    end else if (sel < 18) begin
      pick_sample = 32'sh8000_0000;
    end else if (sel < 25) begin
      pick_sample = noise;
    end else begin
      ramp_base = ramp_base + ramp_step;
      pick_sample = ramp_base + noise;
    end
  endfunction

  task automatic add_item(input logic [FuncW-1:0] f, input logic signed [DataW-1:0] v,
                          input bit drain);
    smoother_item_t it;
    it.func = f;
    it.value = v;
    it.drain = drain;
    pending_items.push_back(it);
  endtask

  task automatic write_gain(input logic idx, input logic [GainW-1:0] data);
    @(posedge clk);
    write_enable <= 1'b1;
    reg_index <= idx;
    write_data <= data;
    @(posedge clk);
    write_enable <= 1'b0;
    if (idx == REG_LEVEL_GAIN) begin
      mdl_alpha = data;
    end else begin
      mdl_beta = data;
    end
  endtask

  // Hold until every transaction is out and the block has settled
  task automatic wait_idle();
    do begin
      @(posedge clk);
    end while (pending_items.size() != 0 || sample_valid || expected_out.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_gains(input logic [GainW-1:0] lg, input logic [GainW-1:0] tg);
    wait_idle();
    write_gain(REG_LEVEL_GAIN, lg);
    write_gain(REG_TREND_GAIN, tg);
  endtask

  // Sender: present pending transactions with random gaps
  always @(posedge clk) begin : drive_p
    smoother_item_t nxt;
    bit launch_ok;
    if (rst) begin
      sample_valid <= 1'b0;
      send_gap = 0;
    end else if (!(sample_valid && sample_stall)) begin
      if (sample_valid) begin
        send_gap = draw_gap(send_calm);
      end
      launch_ok = 1'b0;
      if (pending_items.size() != 0) begin
        launch_ok = !pending_items[0].drain
                    || (!sample_valid && expected_out.size() == 0);
      end
      if (send_gap > 0) begin
        send_gap--;
        sample_valid <= 1'b0;
      end else if (launch_ok) begin
        nxt = pending_items.pop_front();
        func <= nxt.func;
        sample <= nxt.value;
        sample_valid <= 1'b1;
      end else begin
        sample_valid <= 1'b0;
      end
    end
  end

  // Receiver: stall for a random gap after each result
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      recv_gap = 0;
    end else begin
      if (result_valid && !result_stall) begin
        recv_gap = draw_gap(recv_calm);
      end
      if (recv_gap > 0) begin
        recv_gap--;
        result_stall <= 1'b1;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  // Check results against predictions, then predict for accepted inputs
  always @(posedge clk) begin : check_p
    smoother_out_t want;
    smoother_out_t got;
    if (!rst) begin
      if (result_valid && !result_stall) begin
        if (expected_out.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("unexpected result: smoothed %0d trend %0d", smoothed, trend);
          end
        end else begin
          want = expected_out.pop_front();
          if (want.smoothed !== smoothed || want.trend !== trend) begin
            errors++;
            if (errors <= 10) begin
              $display("mismatch: smoothed exp %0d got %0d, trend exp %0d got %0d",
                       want.smoothed, smoothed, want.trend, trend);
            end
          end
        end
      end
      if (sample_valid && !sample_stall) begin
        if (holt_step(func, sample, got.smoothed, got.trend)) begin
          expected_out.push_back(got);
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (sample_valid && !sample_stall) || (result_valid && !result_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL double_exponential_smoother_top");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus: directed cases, then random phases under varied gains
  initial begin : stim_p
    int drain_at;
    int unsigned sel;
    logic [FuncW-1:0] f;
    logic [GainW-1:0] gain_tab[RANDOM_PHASES][2];
    gain_tab = '{'{17'd0, 17'd0}, '{17'd131071, 17'd131071}, '{17'd65536, 17'd65536},
                 '{LEVEL_GAIN_RST, TREND_GAIN_RST}, '{17'd1, 17'd65535},
                 '{17'd65535, 17'd1}, '{17'd65536, 17'd0}, '{17'd0, 17'd65536},
                 '{17'd0, 17'd0}, '{17'd0, 17'd0}};
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset gains: extremes, repeats, set level and the unused code
    add_item(FUNC_NEW, 32'sd0, 1'b0);
    add_item(FUNC_NEW, 32'sh7FFF_FFFF, 1'b0);
    add_item(FUNC_NEW, 32'sh8000_0000, 1'b0);
    add_item(FUNC_REPEAT, 32'sh1234_5678, 1'b0);
    add_item(FUNC_REPEAT, 32'sh0, 1'b0);
    add_item(FUNC_SET, 32'sh7FFF_FFFF, 1'b0);
    add_item(FUNC_NEW, 32'sh7FFF_FFFF, 1'b0);
    add_item(FUNC_UNUSED, 32'sh5A5A_5A5A, 1'b0);
    add_item(FUNC_REPEAT, 32'sh0, 1'b0);
    add_item(FUNC_SET, 32'sh8000_0000, 1'b0);
    add_item(FUNC_NEW, 32'sd1, 1'b0);
    add_item(FUNC_NEW, -32'sd1, 1'b0);
    add_item(FUNC_NEW, 32'sh0001_0000, 1'b0);

    // Unity gains: drive the level and trend into saturation
    set_gains(17'd65536, 17'd65536);
    @(negedge clk);
    add_item(FUNC_NEW, 32'sh7FFF_FFFF, 1'b0);
    add_item(FUNC_NEW, 32'sh8000_0000, 1'b0);
    add_item(FUNC_REPEAT, 32'sh0, 1'b0);
    add_item(FUNC_SET, 32'sh7FFF_FFFF, 1'b0);
    add_item(FUNC_NEW, 32'sh7FFF_FFFF, 1'b0);
    add_item(FUNC_NEW, 32'sh8000_0000, 1'b0);
    add_item(FUNC_SET, 32'sh8000_0000, 1'b0);
    add_item(FUNC_NEW, 32'sh7FFF_FFFF, 1'b0);
    add_item(FUNC_REPEAT, 32'sh0, 1'b0);
    add_item(FUNC_UNUSED, 32'shFFFF_FFFF, 1'b0);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p >= RANDOM_PHASES - 2) begin
        set_gains(GainW'($urandom_range(0, 131071)), GainW'($urandom_range(0, 131071)));
      end else begin
        set_gains(gain_tab[p][0], gain_tab[p][1]);
      end
      @(negedge clk);
      ramp_step = int'($urandom_range(0, 2097152)) - 1048576;
      drain_at = $urandom_range(10, ITEMS_PER_PHASE - 10);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        sel = $urandom_range(0, 99);
        if (sel < 58) begin
          f = FUNC_NEW;
        end else if (sel < 78) begin
          f = FUNC_REPEAT;
        end else if (sel < 92) begin
          f = FUNC_SET;
        end else begin
          f = FUNC_UNUSED;
        end
        add_item(f, (f == FUNC_NEW || f == FUNC_SET) ? pick_sample() : $urandom,
                 i == drain_at);
      end
    end

    wait_idle();
    if (errors == 0 && expected_out.size() == 0) begin
      $display("PASS double_exponential_smoother_top");
    end else begin
      $display("FAIL double_exponential_smoother_top");
    end
    $finish;
  end

endmodule
